// ===== rtl/core/percent_decode_uri_stream_unit_defines.svh =====
// Assertion macros for the percent decoder checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef PERCENT_DECODE_URI_STREAM_UNIT_DEFINES_SVH
`define PERCENT_DECODE_URI_STREAM_UNIT_DEFINES_SVH

// check that a condition holds at every clock edge out of reset
`define PDUS_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("percent decoder check failed");

// check that a cause is followed in the next cycle by an effect
`define PDUS_ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("percent decoder check failed");

`endif

// ===== rtl/core/pdus_pkg.sv =====
// Types, constants and helpers shared by the percent decoder modules.
// No dependencies.
package pdus_pkg;

  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChPlus     = 8'h2b;
  localparam logic [7:0] ChQuestion = 8'h3f;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] CaseBit    = 8'h20;
  localparam logic [7:0] SafeLow    = 8'h26;
  localparam logic [7:0] SafeHigh   = 8'h7e;

  localparam int unsigned ModeUriBit      = 0;
  localparam int unsigned ModeRedirectBit = 1;

  // queue depth must be a power of two
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [1:0] {
    PhUsual   = 2'd0,
    PhQuoted  = 2'd1,
    PhSecond  = 2'd2,
    PhStopped = 2'd3
  } phase_e;

  typedef enum logic {
    KindData = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    logic       end_status;
    logic       last_of_run;
  } out_t;

  // one accepted byte, classified: up to three data bytes and an optional end item
  typedef struct packed {
    logic [1:0]       n_data;
    logic [2:0][7:0]  data;
    logic             has_end;
    logic             end_status;
  } cmd_t;

  // bit 4 set for a byte that is not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] l;
    logic [7:0] t;
    l = c | CaseBit;
    hex_value = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      hex_value = {1'b0, t[3:0]};
    end else if (l >= 8'h61 && l <= 8'h66) begin
      t = l - 8'h57;
      hex_value = {1'b0, t[3:0]};
    end
  endfunction

endpackage

// ===== rtl/core/pdus_front.sv =====
// Front end: holds the mode register and decode state, classifies each byte.
// Depends on pdus_pkg.
module pdus_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  input  pdus_pkg::in_t  in_i,
  output logic           cmd_valid_o,
  output pdus_pkg::cmd_t cmd_o
);
  import pdus_pkg::*;

  logic [1:0] mode_q;
  phase_e     phase_q, phase_d;
  logic [3:0] hn_q, hn_d;
  logic [7:0] fhc_q, fhc_d;

  logic [7:0] ch;
  logic [4:0] v;
  logic [7:0] dec;
  logic       any_mode;
  logic       early;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      phase_q <= PhUsual;
      hn_q    <= '0;
      fhc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_valid_i) begin
        phase_q <= phase_d;
        hn_q    <= hn_d;
        fhc_q   <= fhc_d;
      end
    end
  end

  always_comb begin
    ch       = in_i.in_byte;
    v        = hex_value(ch);
    dec      = {hn_q, v[3:0]};
    any_mode = |mode_q;
    early    = 1'b0;
    phase_d  = phase_q;
    hn_d     = hn_q;
    fhc_d    = fhc_q;
    cmd_o    = '0;
    case (phase_q)
      PhUsual: begin
        if (ch == ChQuestion && any_mode) begin
          cmd_o.n_data  = 2'd1;
          cmd_o.data[0] = ch;
          phase_d       = PhStopped;
        end else if (ch == ChPercent) begin
          phase_d = PhQuoted;
        end else if (ch == ChPlus) begin
          cmd_o.n_data  = 2'd1;
          cmd_o.data[0] = ChSpace;
        end else begin
          cmd_o.n_data  = 2'd1;
          cmd_o.data[0] = ch;
        end
      end
      PhQuoted: begin
        if (!v[4]) begin
          hn_d    = v[3:0];
          fhc_d   = ch;
          phase_d = PhSecond;
        end else begin
          cmd_o.n_data  = 2'd1;
          cmd_o.data[0] = ch;
          phase_d       = PhUsual;
        end
      end
      PhSecond: begin
        phase_d = PhUsual;
        if (!v[4]) begin
          if (v >= 5'd10 && any_mode && dec == ChQuestion) begin
            cmd_o.n_data  = 2'd1;
            cmd_o.data[0] = dec;
            phase_d       = PhStopped;
          end else if (v >= 5'd10 && mode_q[ModeUriBit]) begin
            cmd_o.n_data  = 2'd1;
            cmd_o.data[0] = dec;
          end else if (mode_q[ModeRedirectBit] && (dec < SafeLow || dec > SafeHigh)) begin
            cmd_o.n_data  = 2'd3;
            cmd_o.data[0] = ChPercent;
            cmd_o.data[1] = fhc_q;
            cmd_o.data[2] = ch;
          end else begin
            cmd_o.n_data  = 2'd1;
            cmd_o.data[0] = dec;
          end
        end
      end
      PhStopped: begin
        early = 1'b1;
      end
      default: begin
        phase_d = PhUsual;
      end
    endcase
    if (in_i.last_in) begin
      cmd_o.has_end    = 1'b1;
      cmd_o.end_status = early;
      phase_d          = PhUsual;
      hn_d             = '0;
      fhc_d            = '0;
    end
    cmd_valid_o = in_valid_i && (cmd_o.has_end || cmd_o.n_data != 2'd0);
  end

endmodule

// ===== rtl/core/pdus_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on pdus_pkg.
module pdus_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pdus_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output pdus_pkg::cmd_t rdata_o,
  output logic           empty_o
);
  import pdus_pkg::*;

  cmd_t            mem_q [QDepth];
  logic [QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QAw:0]    count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == (QAw+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/pdus_back.sv =====
// Back end: steps through each queued command and feeds the output register.
// Depends on pdus_pkg.
module pdus_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  pdus_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output pdus_pkg::out_t out_o
);
  import pdus_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  out_t       out_q, out_d;
  logic [2:0] total;
  logic       load;
  logic       is_last;

  assign empty = !valid_q;
  assign out_o = out_q;

  always_comb begin
    total     = {1'b0, cmd_i.n_data} + {2'b00, cmd_i.has_end};
    load      = !cmd_empty_i && (!valid_q || pop);
    is_last   = ({1'b0, idx_q} == total - 3'd1);
    cmd_pop_o = load && is_last;
    idx_d     = idx_q;
    valid_d   = valid_q;
    out_d     = out_q;
    if (load) begin
      valid_d         = 1'b1;
      idx_d           = is_last ? 2'd0 : idx_q + 2'd1;
      out_d.last_of_run = is_last;
      if (idx_q < cmd_i.n_data) begin
        out_d.item_kind  = KindData;
        out_d.data_byte  = cmd_i.data[idx_q];
        out_d.end_status = 1'b0;
      end else begin
        out_d.item_kind  = KindEnd;
        out_d.data_byte  = '0;
        out_d.end_status = cmd_i.end_status;
      end
    end else if (pop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== rtl/core/percent_decode_uri_stream_unit.sv =====
// Top level of the streaming percent decoder: front end, command queue, back end.
// Depends on pdus_pkg, pdus_front, pdus_cmd_fifo and pdus_back.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   input    | push / full      | in_i  : in_byte, last_in
//   result   | empty / pop      | out_o : item_kind, data_byte, end_status,
//            |                  |         last_of_run
//   config   | cfg_we_i         | cfg_wdata_i : mode
//
// One byte is taken per cycle while the two-entry command queue has room.
// The back end issues a byte's results one at a time; a byte causing k results holds
// its queue entry until the last of them is loaded, so re-escapes and end items slow intake.
// A byte's first result passes through the command queue and then the output register.
// Reset clears the mode, the decode state, the queue and the output valid flag, not the output data.
// A stall on pop holds the output register and backs up through the queue to full.
module percent_decode_uri_stream_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_wdata_i,
  input  logic            push,
  output logic            full,
  input  pdus_pkg::in_t   in_i,
  output logic            empty,
  input  logic            pop,
  output pdus_pkg::out_t  out_o
);
  import pdus_pkg::*;

  logic cmd_valid;
  cmd_t cmd_wr, cmd_rd;
  logic cmd_empty;
  logic cmd_pop;

  pdus_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (push && !full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  pdus_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd_wr),
    .full_o  (full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty)
  );

  pdus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/pdus_checker.sv =====
// Port-level checks for the percent decoder, bound to the top level.
// Depends on pdus_pkg and percent_decode_uri_stream_unit_defines.svh.
`include "percent_decode_uri_stream_unit_defines.svh"

module pdus_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic           full,
  input  logic           empty,
  input  logic           pop,
  input  pdus_pkg::out_t out_o
);
  import pdus_pkg::*;

  `PDUS_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_o))
  `PDUS_ASSERT_NEXT(a_full_needs_push, clk_i, rst_ni, !full && !push, !full)
  `PDUS_ASSERT(a_end_is_last, clk_i, rst_ni, empty || out_o.item_kind == KindData || out_o.last_of_run)
  `PDUS_ASSERT(a_data_no_status, clk_i, rst_ni, empty || out_o.item_kind == KindEnd || !out_o.end_status)
  `PDUS_ASSERT(a_end_zero_byte, clk_i, rst_ni, empty || out_o.item_kind == KindData || out_o.data_byte == 8'h00)

endmodule

bind percent_decode_uri_stream_unit pdus_checker u_pdus_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_o       (out_o)
);
